[rtl/tls_pkg.sv]
// Shared types and constants for the triangle lattice scan block.
package tls_pkg;

    localparam int COORD_BITS = 12;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * COORD_BITS + 2;
    localparam int SUM_BITS   = 2 * COORD_BITS + 4;
    localparam int IDX_BITS   = 3;
    localparam int IN_BYTES   = 8;

    localparam logic [IDX_BITS-1:0] REG_A_X = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_A_Y = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_B_X = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_B_Y = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_C_X = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_C_Y = 3'd5;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [SUM_BITS-1:0]   sum_t;

    // Per-triangle values, settled after each register write
    typedef struct packed {
        coord_t xmin;
        coord_t xmax;
        coord_t ymin;
        coord_t ymax;
        diff_t  ks_x;   // cy - ay
        diff_t  ks_y;   // ax - cx
        diff_t  kt_x;   // ay - by
        diff_t  kt_y;   // bx - ax
        sum_t   area2;  // twice the signed area
        sum_t   s0;
        sum_t   t0;
    } tls_geom_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
    } tls_point_t;

endpackage

[rtl/tls_setup.sv]
// Vertex registers and the two-stage precompute of box and edge terms.
module tls_setup
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tls_pkg::IDX_BITS-1:0]  cfg_index,
    input  logic [tls_pkg::COORD_BITS-1:0] cfg_data,
    output tls_pkg::tls_geom_t            geom,
    output logic                          geom_ok
);
    import tls_pkg::*;

    localparam logic [1:0] SETTLE = 2'd2;

    coord_t ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic [1:0] cnt_reg, cnt_next;

    // stage 1
    prod_t dp1_reg, dp2_reg, sp1_reg, sp2_reg, tp1_reg, tp2_reg;
    diff_t ks_x_reg, ks_y_reg, kt_x_reg, kt_y_reg;
    coord_t xmin_reg, xmax_reg, ymin_reg, ymax_reg;
    diff_t bxa, cya, bya, cxa;
    coord_t xmin_next, xmax_next, ymin_next, ymax_next;

    // stage 2
    tls_geom_t geom_reg;

    logic wr;
    assign wr        = cfg_valid && cfg_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg <= '0;
            ay_reg <= '0;
            bx_reg <= '0;
            by_reg <= '0;
            cx_reg <= '0;
            cy_reg <= '0;
        end
        else if (wr)
        begin
            unique case (cfg_index)
                REG_A_X: ax_reg <= cfg_data;
                REG_A_Y: ay_reg <= cfg_data;
                REG_B_X: bx_reg <= cfg_data;
                REG_B_Y: by_reg <= cfg_data;
                REG_C_X: cx_reg <= cfg_data;
                REG_C_Y: cy_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (wr)
            cnt_next = SETTLE;
        else if (cnt_reg != 2'd0)
            cnt_next = cnt_reg - 2'd1;
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= SETTLE;
        else
            cnt_reg <= cnt_next;
    end

    assign geom_ok = (cnt_reg == 2'd0);

    assign bxa = DIFF_BITS'(bx_reg) - DIFF_BITS'(ax_reg);
    assign cya = DIFF_BITS'(cy_reg) - DIFF_BITS'(ay_reg);
    assign bya = DIFF_BITS'(by_reg) - DIFF_BITS'(ay_reg);
    assign cxa = DIFF_BITS'(cx_reg) - DIFF_BITS'(ax_reg);

    always_comb
    begin
        xmin_next = (ax_reg < bx_reg) ? ax_reg : bx_reg;
        if (cx_reg < xmin_next)
            xmin_next = cx_reg;
        xmax_next = (ax_reg > bx_reg) ? ax_reg : bx_reg;
        if (cx_reg > xmax_next)
            xmax_next = cx_reg;
        ymin_next = (ay_reg < by_reg) ? ay_reg : by_reg;
        if (cy_reg < ymin_next)
            ymin_next = cy_reg;
        ymax_next = (ay_reg > by_reg) ? ay_reg : by_reg;
        if (cy_reg > ymax_next)
            ymax_next = cy_reg;
    end

    // free running: the settle counter covers the two stages
    always_ff @(posedge clk)
    begin
        dp1_reg  <= PROD_BITS'(bxa) * PROD_BITS'(cya);
        dp2_reg  <= PROD_BITS'(bya) * PROD_BITS'(cxa);
        sp1_reg  <= PROD_BITS'(ay_reg) * PROD_BITS'(cx_reg);
        sp2_reg  <= PROD_BITS'(ax_reg) * PROD_BITS'(cy_reg);
        tp1_reg  <= PROD_BITS'(ax_reg) * PROD_BITS'(by_reg);
        tp2_reg  <= PROD_BITS'(ay_reg) * PROD_BITS'(bx_reg);
        ks_x_reg <= cya;
        ks_y_reg <= DIFF_BITS'(ax_reg) - DIFF_BITS'(cx_reg);
        kt_x_reg <= DIFF_BITS'(ay_reg) - DIFF_BITS'(by_reg);
        kt_y_reg <= bxa;
        xmin_reg <= xmin_next;
        xmax_reg <= xmax_next;
        ymin_reg <= ymin_next;
        ymax_reg <= ymax_next;
    end

    always_ff @(posedge clk)
    begin
        geom_reg.xmin  <= xmin_reg;
        geom_reg.xmax  <= xmax_reg;
        geom_reg.ymin  <= ymin_reg;
        geom_reg.ymax  <= ymax_reg;
        geom_reg.ks_x  <= ks_x_reg;
        geom_reg.ks_y  <= ks_y_reg;
        geom_reg.kt_x  <= kt_x_reg;
        geom_reg.kt_y  <= kt_y_reg;
        geom_reg.area2 <= SUM_BITS'(dp1_reg) - SUM_BITS'(dp2_reg);
        geom_reg.s0    <= SUM_BITS'(sp1_reg) - SUM_BITS'(sp2_reg);
        geom_reg.t0    <= SUM_BITS'(tp1_reg) - SUM_BITS'(tp2_reg);
    end

    assign geom = geom_reg;

endmodule

[rtl/tls_walker.sv]
// Scan position register: steps row-major through the bounding box.
module tls_walker
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  logic                  restart,
    input  tls_pkg::tls_geom_t    geom,
    input  logic                  b_ready,
    output logic                  a_valid,
    output logic                  a_ready,
    output tls_pkg::tls_point_t   point
);
    import tls_pkg::*;

    coord_t x_reg, x_next, y_reg, y_next;
    logic   started_reg;
    logic   a_valid_reg, a_valid_next;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        if (restart || !started_reg)
        begin
            x_next = geom.xmin;
            y_next = geom.ymin;
        end
        else if (x_reg >= geom.xmax)
        begin
            x_next = geom.xmin;
            y_next = (y_reg >= geom.ymax) ? geom.ymin : y_reg + coord_t'(1);
        end
        else
        begin
            x_next = x_reg + coord_t'(1);
        end
    end

    assign a_ready = !a_valid_reg || b_ready;

    always_comb
    begin
        if (take)
            a_valid_next = 1'b1;
        else if (b_ready)
            a_valid_next = 1'b0;
        else
            a_valid_next = a_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg       <= '0;
            y_reg       <= '0;
            started_reg <= 1'b0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            if (take)
            begin
                x_reg       <= x_next;
                y_reg       <= y_next;
                started_reg <= 1'b1;
            end
        end
    end

    assign a_valid    = a_valid_reg;
    assign point.x    = x_reg;
    assign point.y    = y_reg;
    assign point.last = (x_reg == geom.xmax) && (y_reg == geom.ymax);

endmodule

[rtl/tls_edge.sv]
// Edge-function products, inside test and the output register.
module tls_edge
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            a_valid,
    input  tls_pkg::tls_point_t             point,
    input  tls_pkg::tls_geom_t              geom,
    output logic                            b_ready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [2*tls_pkg::COORD_BITS-1:0] m_tdata,
    output logic                            m_tlast,
    output logic                            m_tuser
);
    import tls_pkg::*;

    logic   b_valid_reg;
    coord_t bx_reg, by_reg;
    logic   blast_reg;
    prod_t  ps1_reg, ps2_reg, pt1_reg, pt2_reg;

    logic   o_valid_reg;
    logic   o_ready;
    logic [2*COORD_BITS-1:0] o_data_reg;
    logic   o_last_reg, o_in_reg;

    sum_t   s_sum, t_sum, st_sum;
    logic   hit;

    function automatic logic in_span(sum_t v, sum_t d);
        if (d > 0)
            return (v >= 0) && (v <= d);
        else
            return (v <= 0) && (v >= d);
    endfunction

    assign o_ready = !o_valid_reg || m_tready;
    assign b_ready = !b_valid_reg || o_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_ready)
                b_valid_reg <= a_valid;
            if (o_ready)
                o_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready)
        begin
            bx_reg    <= point.x;
            by_reg    <= point.y;
            blast_reg <= point.last;
            ps1_reg   <= PROD_BITS'(geom.ks_x) * PROD_BITS'(point.x);
            ps2_reg   <= PROD_BITS'(geom.ks_y) * PROD_BITS'(point.y);
            pt1_reg   <= PROD_BITS'(geom.kt_x) * PROD_BITS'(point.x);
            pt2_reg   <= PROD_BITS'(geom.kt_y) * PROD_BITS'(point.y);
        end
    end

    assign s_sum  = geom.s0 + SUM_BITS'(ps1_reg) + SUM_BITS'(ps2_reg);
    assign t_sum  = geom.t0 + SUM_BITS'(pt1_reg) + SUM_BITS'(pt2_reg);
    assign st_sum = s_sum + t_sum;
    // zero area: nothing inside
    assign hit    = (geom.area2 != '0) && in_span(s_sum, geom.area2)
                    && in_span(t_sum, geom.area2) && in_span(st_sum, geom.area2);

    always_ff @(posedge clk)
    begin
        if (o_ready)
        begin
            o_data_reg <= {by_reg, bx_reg};
            o_last_reg <= blast_reg;
            o_in_reg   <= hit;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;
    assign m_tlast  = o_last_reg;
    assign m_tuser  = o_in_reg;

endmodule

[rtl/triangle_lattice_scan.sv]
// Top level of the triangle lattice scan block.
//
// Usage: write the six vertex coordinates on the cfg channel (index 0..5 =
// a.x, a.y, b.x, b.y, c.x, c.y; other indexes are ignored). Each beat on
// the s_ channel is one tick: restart=1 goes to the first bounding-box
// position, restart=0 steps to the next one, row by row from low y and
// low x. Each tick gives one m_ beat with the point, the inside flag in
// m_tuser and m_tlast on the box's final position; the scan then wraps.
// Each tick passes the position, multiply and output registers; one tick is
// taken every cycle while the pipeline flows. The inside test is exact
// integer edge arithmetic spread over one multiply stage and one
// add/compare stage; box and edge terms are precomputed in two stages.
// After reset and after every cfg write, s_tready stays low while those
// terms settle. Reset clears the vertices to zero and the scan to not
// started (the first tick always starts at the box minimum).
// When the receiver stalls, the output register holds its beat, the two
// stages behind it fill, and then s_tready drops.
module triangle_lattice_scan
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tls_pkg::IN_BYTES-1:0]        s_tdata,   // [0] restart, rest zero
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [2*tls_pkg::COORD_BITS-1:0]    m_tdata,   // [11:0] point_x, [23:12] point_y
    output logic                                m_tlast,   // last
    output logic                                m_tuser,   // [0] inside_res
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tls_pkg::IDX_BITS-1:0]        cfg_index,
    input  logic [tls_pkg::COORD_BITS-1:0]      cfg_data
);
    import tls_pkg::*;

    tls_geom_t  geom;
    logic       geom_ok;
    tls_point_t point;
    logic       a_valid, a_ready, b_ready;
    logic       take;

    assign s_tready = geom_ok && a_ready;
    assign take     = s_tvalid && s_tready;

    tls_setup u_setup
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom),
        .geom_ok   (geom_ok)
    );

    tls_walker u_walker
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .restart (s_tdata[0]),
        .geom    (geom),
        .b_ready (b_ready),
        .a_valid (a_valid),
        .a_ready (a_ready),
        .point   (point)
    );

    tls_edge u_edge
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .a_valid  (a_valid),
        .point    (point),
        .geom     (geom),
        .b_ready  (b_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> !s_tready)
        else $error("tick taken while box terms settle");

    a_restart_to_min: assert property (@(posedge clk) disable iff (!rst_n)
        (take && s_tdata[0]) |=> (point.x == geom.xmin && point.y == geom.ymin))
        else $error("restart did not land on box minimum");

    a_take_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> a_valid)
        else $error("accepted tick lost from position stage");

    a_stalled_pos_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid && !b_ready) |=> (a_valid && $stable(point.x) && $stable(point.y)))
        else $error("scan position moved under stall");

endmodule
